>>> design/fdvvr_pkg.sv
// Shared types, codes and constants for the flow direction vote velocity ramp.
`timescale 1ns / 1ps
package fdvvr_pkg;

	localparam int unsigned MAX_SAMPLES_DEF = 4096;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned CNT_W = 13;
	localparam int unsigned ADDR_W = 5;

	// sample kinds after classification
	localparam logic [2:0] KIND_MOVE  = 3'd0;
	localparam logic [2:0] KIND_UP    = 3'd1;
	localparam logic [2:0] KIND_DOWN  = 3'd2;
	localparam logic [2:0] KIND_LEFT  = 3'd3;
	localparam logic [2:0] KIND_RIGHT = 3'd4;
	localparam logic [2:0] KIND_EOF   = 3'd5;

	// commands
	localparam logic [1:0] DIR_UP    = 2'd0;
	localparam logic [1:0] DIR_DOWN  = 2'd1;
	localparam logic [1:0] DIR_LEFT  = 2'd2;
	localparam logic [1:0] DIR_RIGHT = 2'd3;

	// register indexes
	localparam logic [2:0] REG_NOISE_THRESHOLD  = 3'd0;
	localparam logic [2:0] REG_MOVE_MINIMUM     = 3'd1;
	localparam logic [2:0] REG_BACKGROUND_LIMIT = 3'd2;
	localparam logic [2:0] REG_LINEAR_MAX       = 3'd3;
	localparam logic [2:0] REG_ANGULAR_MAX      = 3'd4;
	localparam logic [2:0] REG_LINEAR_STEP      = 3'd5;
	localparam logic [2:0] REG_ANGULAR_STEP     = 3'd6;

	// register reset values
	localparam logic [7:0]  NOISE_THRESHOLD_RST  = 8'd38;
	localparam logic [12:0] MOVE_MINIMUM_RST     = 13'd500;
	localparam logic [12:0] BACKGROUND_LIMIT_RST = 13'd1200;
	localparam logic [6:0]  LINEAR_MAX_RST       = 7'd52;
	localparam logic [7:0]  ANGULAR_MAX_RST      = 8'd182;
	localparam logic [5:0]  LINEAR_STEP_RST      = 6'd2;
	localparam logic [6:0]  ANGULAR_STEP_RST     = 7'd10;

	typedef struct packed {
		logic [7:0]  noise_threshold;
		logic [12:0] move_minimum;
		logic [12:0] background_limit;
		logic [6:0]  linear_max;
		logic [7:0]  angular_max;
		logic [5:0]  linear_step;
		logic [6:0]  angular_step;
	} cfg_t;

	typedef logic [2:0] kind_t;

endpackage

>>> design/fdvvr_front.sv
// Front stage: accepts flow samples, drops noise and classifies each vote.
`timescale 1ns / 1ps
module fdvvr_front
	import fdvvr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // magnitude[7:0], flow_x[23:8], flow_y[39:24]
	input  logic        s_tuser,   // req_type
	input  logic [7:0]  noise_threshold,
	output logic        push,
	output kind_t       push_kind,
	input  logic        q_full
);

	logic              valid_s1;
	kind_t             kind_s1;
	logic [7:0]        mag;
	logic signed [15:0] fx, fy;
	logic [16:0]       ax, ay;
	logic              keep;
	kind_t             kind;

	assign mag = s_tdata[7:0];
	assign fx  = s_tdata[23:8];
	assign fy  = s_tdata[39:24];

	always_comb begin
		ax = fx[15] ? 17'(-$signed({fx[15], fx})) : {1'b0, fx};
		ay = fy[15] ? 17'(-$signed({fy[15], fy})) : {1'b0, fy};
		keep = s_tuser || (mag >= noise_threshold);
		if (s_tuser) begin
			kind = KIND_EOF;
		end else if (fx == 16'sd0 || fy == 16'sd0) begin
			kind = KIND_MOVE;
		end else if (ay > ax) begin
			kind = fy[15] ? KIND_UP : KIND_DOWN;
		end else begin
			kind = fx[15] ? KIND_RIGHT : KIND_LEFT;
		end
	end

	assign push      = valid_s1 && !q_full;
	assign push_kind = kind_s1;
	assign s_tready  = !valid_s1 || !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready) begin
			kind_s1 <= kind;
		end
	end

endmodule

>>> design/fdvvr_queue.sv
// Small flop queue of classified sample kinds between front and back.
`timescale 1ns / 1ps
module fdvvr_queue
	import fdvvr_pkg::*;
#(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  kind_t push_kind,
	output logic  full,
	input  logic  pop,
	output kind_t pop_kind,
	output logic  empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_QW = $clog2(DEPTH + 1);

	kind_t              mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_QW-1:0]  count_q;

	assign full     = (count_q == CNT_QW'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_kind = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_kind;
		end
	end

endmodule

>>> design/fdvvr_back.sv
// Back end: vote counters, end-of-frame decision, target step and velocity slew.
`timescale 1ns / 1ps
module fdvvr_back
	import fdvvr_pkg::*;
#(
	parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        q_empty,
	input  kind_t       q_kind,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata  // direction[1:0], linear_vel[9:2], angular_vel[18:10],
	                             // moving_count[31:19]
);

	localparam logic [CNT_W-1:0] CNT_LIM =
		CNT_W'((MAX_SAMPLES < 8191) ? MAX_SAMPLES : 8191);

	logic adv;

	// running counters
	logic [CNT_W-1:0] up_q, down_q, left_q, right_q, moved_q;
	// snapshot of a finished frame
	logic             valid_s1;
	logic [CNT_W-1:0] up_s1, down_s1, left_s1, right_s1, moved_s1;
	// decision
	logic             valid_s2;
	logic [1:0]       best_s2;
	logic [CNT_W-1:0] moved_s2;
	// target step
	logic             valid_s3;
	logic [1:0]       best_s3;
	logic [CNT_W-1:0] moved_s3;
	logic signed [7:0] tgt_lin_q, cur_lin_q;
	logic signed [8:0] tgt_ang_q, cur_ang_q;
	// output register
	logic             out_valid_q;
	logic [1:0]       out_dir_q;
	logic [CNT_W-1:0] out_moved_q;

	function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
		bump = (c < CNT_LIM) ? c + 1'b1 : c;
	endfunction

	function automatic logic signed [10:0] slew(input logic signed [10:0] cur,
	                                             input logic signed [10:0] tgt,
	                                             input logic signed [10:0] amt);
		if (tgt > cur) begin
			slew = (tgt - cur < amt) ? tgt : cur + amt;
		end else if (tgt < cur) begin
			slew = (cur - tgt < amt) ? tgt : cur - amt;
		end else begin
			slew = tgt;
		end
	endfunction

	// whole back end holds while a result waits
	assign adv      = !out_valid_q || m_tready;
	assign pop      = adv && !q_empty;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_moved_q, cur_ang_q, cur_lin_q, out_dir_q};

	// counters and frame snapshot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_q    <= '0;
			down_q  <= '0;
			left_q  <= '0;
			right_q <= '0;
			moved_q <= '0;
		end else if (pop) begin
			if (q_kind == KIND_EOF) begin
				up_q    <= '0;
				down_q  <= '0;
				left_q  <= '0;
				right_q <= '0;
				moved_q <= '0;
			end else begin
				moved_q <= bump(moved_q);
				if (q_kind == KIND_UP)    up_q    <= bump(up_q);
				if (q_kind == KIND_DOWN)  down_q  <= bump(down_q);
				if (q_kind == KIND_LEFT)  left_q  <= bump(left_q);
				if (q_kind == KIND_RIGHT) right_q <= bump(right_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && q_kind == KIND_EOF) begin
			up_s1    <= up_q;
			down_s1  <= down_q;
			left_s1  <= left_q;
			right_s1 <= right_q;
			moved_s1 <= moved_q;
		end
	end

	// first largest vote, then swap up and down on background motion
	logic [1:0]       best01, best23, best;
	logic [CNT_W-1:0] max01, max23;

	always_comb begin
		best01 = (down_s1 > up_s1) ? DIR_DOWN : DIR_UP;
		max01  = (down_s1 > up_s1) ? down_s1 : up_s1;
		best23 = (right_s1 > left_s1) ? DIR_RIGHT : DIR_LEFT;
		max23  = (right_s1 > left_s1) ? right_s1 : left_s1;
		best   = (max23 > max01) ? best23 : best01;
		if (!best[1] && moved_s1 > cfg.background_limit) begin
			best = best ^ 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			best_s2  <= best;
			moved_s2 <= moved_s1;
			best_s3  <= best_s2;
			moved_s3 <= moved_s2;
		end
	end

	// step and clamp the target on the chosen axis
	logic signed [9:0]  lin_sum, lin_lim, lin_clamped;
	logic signed [10:0] ang_sum, ang_lim, ang_clamped;

	always_comb begin
		lin_lim = $signed({3'b000, cfg.linear_max});
		ang_lim = $signed({3'b000, cfg.angular_max});
		if (best_s2 == DIR_UP) begin
			lin_sum = 10'(tgt_lin_q) + $signed({4'b0000, cfg.linear_step});
		end else begin
			lin_sum = 10'(tgt_lin_q) - $signed({4'b0000, cfg.linear_step});
		end
		if (best_s2 == DIR_LEFT) begin
			ang_sum = 11'(tgt_ang_q) + $signed({4'b0000, cfg.angular_step});
		end else begin
			ang_sum = 11'(tgt_ang_q) - $signed({4'b0000, cfg.angular_step});
		end
		priority if (lin_sum > lin_lim) begin
			lin_clamped = lin_lim;
		end else if (lin_sum < -lin_lim) begin
			lin_clamped = -lin_lim;
		end else begin
			lin_clamped = lin_sum;
		end
		priority if (ang_sum > ang_lim) begin
			ang_clamped = ang_lim;
		end else if (ang_sum < -ang_lim) begin
			ang_clamped = -ang_lim;
		end else begin
			ang_clamped = ang_sum;
		end
	end

	// slew toward the stored target by half a step
	logic signed [10:0] lin_next, ang_next;

	always_comb begin
		lin_next = slew(11'(cur_lin_q), 11'(tgt_lin_q),
		                $signed({6'b000000, cfg.linear_step[5:1]}));
		ang_next = slew(11'(cur_ang_q), 11'(tgt_ang_q),
		                $signed({5'b00000, cfg.angular_step[6:1]}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
			tgt_lin_q   <= '0;
			tgt_ang_q   <= '0;
			cur_lin_q   <= '0;
			cur_ang_q   <= '0;
		end else if (adv) begin
			valid_s1    <= pop && (q_kind == KIND_EOF);
			valid_s2    <= valid_s1 && (moved_s1 > cfg.move_minimum);
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
			if (valid_s2) begin
				if (!best_s2[1]) begin
					tgt_lin_q <= 8'(lin_clamped);
				end else begin
					tgt_ang_q <= 9'(ang_clamped);
				end
			end
			if (valid_s3) begin
				cur_lin_q <= 8'(lin_next);
				cur_ang_q <= 9'(ang_next);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s3) begin
			out_dir_q   <= best_s3;
			out_moved_q <= moved_s3;
		end
	end

endmodule

>>> design/flow_direction_vote_velocity_ramp.sv
// Top level: register port, front classifier, queue and vote/velocity back end.
`timescale 1ns / 1ps
// Takes one flow sample per clock on the input stream. A one-stage classifier
// drops samples under the noise threshold and turns the rest into a vote kind;
// a four-entry queue feeds the back end, which counts votes at one kind per
// cycle. An end-of-frame transfer leaves the counters cleared for the next
// frame at once, and its command, if enough samples moved, goes through the
// classifier register, queue, snapshot, decision and target step to the slew
// in the output register. The back end holds only while a result waits on the
// output, and the input keeps taking transfers until the queue fills.
module flow_direction_vote_velocity_ramp
	import fdvvr_pkg::*;
#(
	parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [39:0]       s_tdata,  // magnitude[7:0], flow_x[23:8], flow_y[39:24]
	input  logic              s_tuser,  // req_type
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [31:0]       m_tdata,  // direction[1:0], linear_vel[9:2],
	                                    // angular_vel[18:10], moving_count[31:19]
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	cfg_t  cfg_q;
	logic  push, q_full, q_empty, pop;
	kind_t push_kind, pop_kind;
	logic  wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.noise_threshold  <= NOISE_THRESHOLD_RST;
			cfg_q.move_minimum     <= MOVE_MINIMUM_RST;
			cfg_q.background_limit <= BACKGROUND_LIMIT_RST;
			cfg_q.linear_max       <= LINEAR_MAX_RST;
			cfg_q.angular_max      <= ANGULAR_MAX_RST;
			cfg_q.linear_step      <= LINEAR_STEP_RST;
			cfg_q.angular_step     <= ANGULAR_STEP_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_NOISE_THRESHOLD:  cfg_q.noise_threshold  <= pwdata[7:0];
				REG_MOVE_MINIMUM:     cfg_q.move_minimum     <= pwdata[12:0];
				REG_BACKGROUND_LIMIT: cfg_q.background_limit <= pwdata[12:0];
				REG_LINEAR_MAX:       cfg_q.linear_max       <= pwdata[6:0];
				REG_ANGULAR_MAX:      cfg_q.angular_max      <= pwdata[7:0];
				REG_LINEAR_STEP:      cfg_q.linear_step      <= pwdata[5:0];
				REG_ANGULAR_STEP:     cfg_q.angular_step     <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_NOISE_THRESHOLD:  prdata = {24'd0, cfg_q.noise_threshold};
			REG_MOVE_MINIMUM:     prdata = {19'd0, cfg_q.move_minimum};
			REG_BACKGROUND_LIMIT: prdata = {19'd0, cfg_q.background_limit};
			REG_LINEAR_MAX:       prdata = {25'd0, cfg_q.linear_max};
			REG_ANGULAR_MAX:      prdata = {24'd0, cfg_q.angular_max};
			REG_LINEAR_STEP:      prdata = {26'd0, cfg_q.linear_step};
			REG_ANGULAR_STEP:     prdata = {25'd0, cfg_q.angular_step};
			default:              prdata = 32'd0;
		endcase
	end

	fdvvr_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.noise_threshold (cfg_q.noise_threshold),
		.push            (push),
		.push_kind       (push_kind),
		.q_full          (q_full)
	);

	fdvvr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_kind (push_kind),
		.full      (q_full),
		.pop       (pop),
		.pop_kind  (pop_kind),
		.empty     (q_empty)
	);

	fdvvr_back #(
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_empty  (q_empty),
		.q_kind   (pop_kind),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
